// ----- hdl/line_rasterizer_defines.svh -----
// ----------------------------------------------------------------------------
// line_rasterizer_defines
// Assertion macros used by the line rasterizer checker.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// implication into the next cycle, masked while reset is asserted
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line_rasterizer: check failed");

// implication into the next cycle that also holds across reset
`define LR_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("line_rasterizer: reset check failed");

`endif

// ----- hdl/lr_pkg.sv -----
// ----------------------------------------------------------------------------
// lr_pkg
// Types, widths and register codes of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    // coordinate and datapath widths
    localparam int COORD_WIDTH     = 12;
    localparam int DELTA_WIDTH     = COORD_WIDTH + 1;
    localparam int ERR_WIDTH       = COORD_WIDTH + 3;
    localparam int ADDR_WIDTH      = 32;
    localparam int PITCH_WIDTH     = 16;
    localparam int BPP_WIDTH       = 4;
    localparam int COLOR_WIDTH     = 32;
    localparam int ROW_PROD_WIDTH  = COORD_WIDTH + PITCH_WIDTH + 1;
    localparam int COL_PROD_WIDTH  = COORD_WIDTH + BPP_WIDTH + 1;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRAME_BASE  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_PITCH   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIXEL_BYTES = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRAW_COLOR  = 2'd3;

    localparam logic [ADDR_WIDTH-1:0]  RST_FRAME_BASE  = 32'h0000_0000;
    localparam logic [PITCH_WIDTH-1:0] RST_ROW_PITCH   = 16'd6400;
    localparam logic [BPP_WIDTH-1:0]   RST_PIXEL_BYTES = 4'd4;
    localparam logic [COLOR_WIDTH-1:0] RST_DRAW_COLOR  = 32'h00FF_00FF;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic                          op;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_x;
        logic signed [COORD_WIDTH-1:0] pixel_y;
        logic [ADDR_WIDTH-1:0]         byte_address;
        logic [COLOR_WIDTH-1:0]        pixel_value;
        logic                          last_pixel;
    } out_item_t;

    // classified command, endpoints already ordered
    typedef struct packed {
        logic                          op;
        logic                          steep;
        logic                          down;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] stop_major;
        logic [DELTA_WIDTH-1:0]        delta_major;
        logic [DELTA_WIDTH-1:0]        delta_minor;
    } cmd_t;

    // pixel coordinates from the stepper
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          last;
    } pix_t;

    // configuration seen by the address unit
    typedef struct packed {
        logic [ADDR_WIDTH-1:0]  frame_base;
        logic [PITCH_WIDTH-1:0] row_pitch;
        logic [BPP_WIDTH-1:0]   pixel_bytes;
        logic [COLOR_WIDTH-1:0] draw_color;
    } cfg_t;

    // queue status toward the stepper
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ----- hdl/lr_front.sv -----
// ----------------------------------------------------------------------------
// lr_front
// Accepts input items and classifies line loads into queue commands.
// ----------------------------------------------------------------------------
module lr_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  lr_pkg::in_item_t s_item,
    input  logic             queue_full,
    output logic             push,
    output lr_pkg::cmd_t     cmd
);

    logic signed [lr_pkg::COORD_WIDTH-1:0] x0;
    logic signed [lr_pkg::COORD_WIDTH-1:0] y0;
    logic signed [lr_pkg::COORD_WIDTH-1:0] x1;
    logic signed [lr_pkg::COORD_WIDTH-1:0] y1;
    logic [lr_pkg::DELTA_WIDTH-1:0]        dx;
    logic [lr_pkg::DELTA_WIDTH-1:0]        dy;
    logic [lr_pkg::DELTA_WIDTH-1:0]        ady;
    logic                                  down;
    logic                                  steep;

    // accept whenever the queue has room
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // order endpoints so x rises
    always_comb begin
        if (s_item.start_x > s_item.end_x) begin
            x0 = s_item.end_x;
            y0 = s_item.end_y;
            x1 = s_item.start_x;
            y1 = s_item.start_y;
        end else begin
            x0 = s_item.start_x;
            y0 = s_item.start_y;
            x1 = s_item.end_x;
            y1 = s_item.end_y;
        end
    end

    // spans and shallow/steep class
    always_comb begin
        dx    = {x1[lr_pkg::COORD_WIDTH-1], x1} - {x0[lr_pkg::COORD_WIDTH-1], x0};
        dy    = {y1[lr_pkg::COORD_WIDTH-1], y1} - {y0[lr_pkg::COORD_WIDTH-1], y0};
        down  = dy[lr_pkg::DELTA_WIDTH-1];
        ady   = down ? (~dy + 1'b1) : dy;
        steep = ady > dx;
    end

    // command record
    always_comb begin
        cmd.op          = s_item.op;
        cmd.steep       = steep;
        cmd.down        = down;
        cmd.first_x     = x0;
        cmd.first_y     = y0;
        cmd.stop_major  = steep ? y1 : x1;
        cmd.delta_major = steep ? ady : dx;
        cmd.delta_minor = steep ? dx : ady;
    end

endmodule

// ----- hdl/lr_queue.sv -----
// ----------------------------------------------------------------------------
// lr_queue
// Short command queue between the front and the stepper.
// ----------------------------------------------------------------------------
module lr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lr_pkg::cmd_t          wdata,
    input  logic                  pop,
    output lr_pkg::cmd_t          rdata,
    output lr_pkg::queue_status_t status
);

    lr_pkg::cmd_t                  entry_reg [lr_pkg::QUEUE_DEPTH];
    logic [lr_pkg::QUEUE_AW-1:0]   wptr_reg;
    logic [lr_pkg::QUEUE_AW-1:0]   wptr_next;
    logic [lr_pkg::QUEUE_AW-1:0]   rptr_reg;
    logic [lr_pkg::QUEUE_AW-1:0]   rptr_next;
    logic [lr_pkg::QUEUE_AW:0]     count_reg;
    logic [lr_pkg::QUEUE_AW:0]     count_next;
    logic                          do_push;
    logic                          do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (lr_pkg::QUEUE_AW+1)'(lr_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rptr_reg];

    // pointer and count update
    always_comb begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/lr_back.sv -----
// ----------------------------------------------------------------------------
// lr_back
// Bresenham stepper: holds the active line and issues one pixel per step.
// ----------------------------------------------------------------------------
module lr_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lr_pkg::queue_status_t q_status,
    input  lr_pkg::cmd_t          q_cmd,
    output logic                  q_pop,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output lr_pkg::pix_t          pix
);

    logic                                  active_reg;
    logic                                  active_next;
    logic                                  steep_reg;
    logic                                  steep_next;
    logic                                  down_reg;
    logic                                  down_next;
    logic signed [lr_pkg::COORD_WIDTH-1:0] cur_x_reg;
    logic signed [lr_pkg::COORD_WIDTH-1:0] cur_x_next;
    logic signed [lr_pkg::COORD_WIDTH-1:0] cur_y_reg;
    logic signed [lr_pkg::COORD_WIDTH-1:0] cur_y_next;
    logic signed [lr_pkg::COORD_WIDTH-1:0] stop_reg;
    logic signed [lr_pkg::COORD_WIDTH-1:0] stop_next;
    logic [lr_pkg::DELTA_WIDTH-1:0]        dmaj_reg;
    logic [lr_pkg::DELTA_WIDTH-1:0]        dmaj_next;
    logic [lr_pkg::DELTA_WIDTH-1:0]        dmin_reg;
    logic [lr_pkg::DELTA_WIDTH-1:0]        dmin_next;
    logic [lr_pkg::ERR_WIDTH-1:0]          err_reg;
    logic [lr_pkg::ERR_WIDTH-1:0]          err_next;

    logic                                  is_load;
    logic                                  emit;
    logic                                  last;
    logic                                  minor_move;
    logic [lr_pkg::ERR_WIDTH-1:0]          err_sum;
    logic [lr_pkg::ERR_WIDTH-1:0]          two_maj;
    logic signed [lr_pkg::COORD_WIDTH-1:0] ystep_y;

    // head decode and pop
    assign is_load   = (q_cmd.op == lr_pkg::OP_LOAD);
    assign emit      = !q_status.empty && !is_load && active_reg;
    assign q_pop     = !q_status.empty && (is_load || !active_reg || pix_ready);
    assign pix_valid = emit;

    // pixel at the current position
    assign last     = steep_reg ? (cur_y_reg == stop_reg) : (cur_x_reg == stop_reg);
    assign pix.x    = cur_x_reg;
    assign pix.y    = cur_y_reg;
    assign pix.last = last;

    // error term update
    always_comb begin
        err_sum    = err_reg + {1'b0, dmin_reg, 1'b0};
        two_maj    = {1'b0, dmaj_reg, 1'b0};
        minor_move = err_sum >= two_maj;
        ystep_y    = down_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
    end

    // next line state
    always_comb begin
        active_next = active_reg;
        steep_next  = steep_reg;
        down_next   = down_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        stop_next   = stop_reg;
        dmaj_next   = dmaj_reg;
        dmin_next   = dmin_reg;
        err_next    = err_reg;
        if (q_pop && is_load) begin
            active_next = 1'b1;
            steep_next  = q_cmd.steep;
            down_next   = q_cmd.down;
            cur_x_next  = q_cmd.first_x;
            cur_y_next  = q_cmd.first_y;
            stop_next   = q_cmd.stop_major;
            dmaj_next   = q_cmd.delta_major;
            dmin_next   = q_cmd.delta_minor;
            err_next    = '0;
        end else if (q_pop && emit) begin
            if (last) begin
                active_next = 1'b0;
            end else begin
                err_next = minor_move ? err_sum - two_maj : err_sum;
                if (steep_reg) begin
                    cur_y_next = ystep_y;
                    if (minor_move) begin
                        cur_x_next = cur_x_reg + 1'b1;
                    end
                end else begin
                    cur_x_next = cur_x_reg + 1'b1;
                    if (minor_move) begin
                        cur_y_next = ystep_y;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            steep_reg  <= 1'b0;
            down_reg   <= 1'b0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            stop_reg   <= '0;
            dmaj_reg   <= '0;
            dmin_reg   <= '0;
            err_reg    <= '0;
        end else begin
            active_reg <= active_next;
            steep_reg  <= steep_next;
            down_reg   <= down_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            stop_reg   <= stop_next;
            dmaj_reg   <= dmaj_next;
            dmin_reg   <= dmin_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ----- hdl/lr_addr.sv -----
// ----------------------------------------------------------------------------
// lr_addr
// Two-stage framebuffer address pipeline ending in the output register.
// ----------------------------------------------------------------------------
module lr_addr (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  lr_pkg::pix_t      pix,
    input  lr_pkg::cfg_t      cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output lr_pkg::out_item_t m_item
);

    logic signed [lr_pkg::ROW_PROD_WIDTH-1:0] row_prod;
    logic signed [lr_pkg::COL_PROD_WIDTH-1:0] col_prod;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    lr_pkg::pix_t                  s1_pix_reg;
    logic [lr_pkg::ADDR_WIDTH-1:0] s1_row_reg;
    logic [lr_pkg::ADDR_WIDTH-1:0] s1_col_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    lr_pkg::out_item_t             out_item_reg;
    logic                          s2_en;
    logic                          s1_en;

    // stage enables
    assign s2_en     = !out_valid_reg || m_ready;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign pix_ready = s1_en;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // row and column products, signed coordinate times unsigned factor
    assign row_prod = pix.y * $signed({1'b0, cfg.row_pitch});
    assign col_prod = pix.x * $signed({1'b0, cfg.pixel_bytes});

    always_comb begin
        s1_valid_next  = s1_en ? pix_valid : s1_valid_reg;
        out_valid_next = s2_en ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (s1_en && pix_valid) begin
            s1_pix_reg <= pix;
            s1_row_reg <= lr_pkg::ADDR_WIDTH'(row_prod);
            s1_col_reg <= lr_pkg::ADDR_WIDTH'(col_prod);
        end
    end

    // address sum into the output register
    always_ff @(posedge aclk) begin
        if (s2_en && s1_valid_reg) begin
            out_item_reg.pixel_x      <= s1_pix_reg.x;
            out_item_reg.pixel_y      <= s1_pix_reg.y;
            out_item_reg.byte_address <= cfg.frame_base + s1_row_reg + s1_col_reg;
            out_item_reg.pixel_value  <= cfg.draw_color;
            out_item_reg.last_pixel   <= s1_pix_reg.last;
        end
    end

endmodule

// ----- hdl/line_rasterizer.sv -----
// A step transfer's pixel reaches m_valid via the product stage and the output register.
// Throughput: one item per cycle; the stepper's error add and compare sets one pixel a cycle
// unless pix_ready is low. Loads and steps with no active line use a queue slot, no output.
// Reset: synchronous, active low; clears the queue, line state and pipeline valids, and
// returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line stepper with framebuffer byte addressing.
// ----------------------------------------------------------------------------
module line_rasterizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lr_pkg::in_item_t                    s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lr_pkg::out_item_t                   m_item,
    input  logic                                cfg_we,
    input  logic [lr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [lr_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

    lr_pkg::cfg_t          cfg_reg;
    lr_pkg::cfg_t          cfg_next;
    logic                  push;
    lr_pkg::cmd_t          front_cmd;
    lr_pkg::cmd_t          head_cmd;
    logic                  pop;
    lr_pkg::queue_status_t q_status;
    logic                  pix_valid;
    logic                  pix_ready;
    lr_pkg::pix_t          pix;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                lr_pkg::CFG_FRAME_BASE: begin
                    cfg_next.frame_base = cfg_wdata[lr_pkg::ADDR_WIDTH-1:0];
                end
                lr_pkg::CFG_ROW_PITCH: begin
                    cfg_next.row_pitch = cfg_wdata[lr_pkg::PITCH_WIDTH-1:0];
                end
                lr_pkg::CFG_PIXEL_BYTES: begin
                    cfg_next.pixel_bytes = cfg_wdata[lr_pkg::BPP_WIDTH-1:0];
                end
                lr_pkg::CFG_DRAW_COLOR: begin
                    cfg_next.draw_color = cfg_wdata[lr_pkg::COLOR_WIDTH-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base  <= lr_pkg::RST_FRAME_BASE;
            cfg_reg.row_pitch   <= lr_pkg::RST_ROW_PITCH;
            cfg_reg.pixel_bytes <= lr_pkg::RST_PIXEL_BYTES;
            cfg_reg.draw_color  <= lr_pkg::RST_DRAW_COLOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input side
    lr_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .queue_full (q_status.full),
        .push       (push),
        .cmd        (front_cmd)
    );

    // command queue
    lr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (front_cmd),
        .pop     (pop),
        .rdata   (head_cmd),
        .status  (q_status)
    );

    // line stepper
    lr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_cmd     (head_cmd),
        .q_pop     (pop),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // address pipeline and output register
    lr_addr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .cfg       (cfg_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ----- hdl/lr_checker.sv -----
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_rasterizer_defines.svh"

module lr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input lr_pkg::in_item_t                   s_item,
    input logic                               m_valid,
    input logic                               m_ready,
    input lr_pkg::out_item_t                  m_item,
    input logic                               cfg_we,
    input logic [lr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input logic [lr_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    // a stalled result holds until its transfer
    `LR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // reset empties the output register
    `LR_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn, !m_valid)

    // reset leaves the queue empty and ready for input
    `LR_ASSERT_ALWAYS(a_reset_in, aclk, !aresetn, s_ready)

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);
